// File: rtl/core/modbus_range_frame_filter_defines.svh
// Assertion macros shared by the range frame filter RTL.
`ifndef MODBUS_RANGE_FRAME_FILTER_DEFINES_SVH
`define MODBUS_RANGE_FRAME_FILTER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MRFF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define MRFF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mrff_pkg.sv
// Shared types, constants and the CRC byte step for the range frame filter.
`timescale 1ns / 1ps
package mrff_pkg;

   localparam int FRAC_BITS_DEF = 16;

   localparam logic [15:0] CRC_INIT   = 16'hFFFF;
   localparam logic [15:0] CRC_POLY   = 16'hA001;
   localparam logic [7:0]  COUNT_BYTE = 8'h02;

   // frame byte positions
   localparam logic [2:0] POS_ADDR   = 3'd0;
   localparam logic [2:0] POS_FUNC   = 3'd1;
   localparam logic [2:0] POS_COUNT  = 3'd2;
   localparam logic [2:0] POS_DIST_H = 3'd3;
   localparam logic [2:0] POS_DIST_L = 3'd4;
   localparam logic [2:0] POS_CRC_L  = 3'd5;
   localparam logic [2:0] POS_CRC_H  = 3'd6;

   // register reset values
   localparam logic [7:0]  RST_DEV_ADDR  = 8'h01;
   localparam logic [7:0]  RST_FUNC_CODE = 8'h03;
   localparam logic [15:0] RST_CALIB     = 16'd0;
   localparam logic [15:0] RST_MAX_RAW   = 16'd5000;
   localparam logic [2:0]  RST_EMA_SHIFT = 3'd1;
   localparam logic [15:0] RST_TIMEOUT   = 16'd2000;

   localparam logic [2:0] SHIFT_MIN = 3'd1;
   localparam logic [2:0] SHIFT_MAX = 3'd4;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_DEV_ADDR  = 3'd0,
      REG_FUNC_CODE = 3'd1,
      REG_CALIB     = 3'd2,
      REG_MAX_RAW   = 3'd3,
      REG_EMA_SHIFT = 3'd4,
      REG_TIMEOUT   = 3'd5
   } reg_index_type;

   typedef enum logic [1:0] {
      FS_NONE    = 2'd0,
      FS_ACCEPT  = 2'd1,
      FS_CRC_ERR = 2'd2,
      FS_RANGE   = 2'd3
   } frame_status_type;

   // parser -> filter, one per beat
   typedef struct packed {
      logic             tick;
      frame_status_type status;
      logic [15:0]      cal;
   } event_type;

   // filter -> result register
   typedef struct packed {
      frame_status_type frame_status;
      logic             updated;
      logic             valid_res;
      logic [15:0]      distance;
   } result_type;

   // one byte of Modbus CRC16, LSB first
   function automatic logic [15:0] crc_step(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: rtl/core/mrff_parser.sv
// Frame hunter: header match, running CRC, distance capture, end-of-frame verdict.
`timescale 1ns / 1ps
module mrff_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic                func,
   input  logic [7:0]          rx_byte,
   input  logic [7:0]          device_address,
   input  logic [7:0]          function_code,
   input  logic [15:0]         calib_offset,
   input  logic [15:0]         max_raw,
   output mrff_pkg::event_type evt
);
   import mrff_pkg::*;

   logic [2:0]  pos_ff, pos_in;
   logic [15:0] crc_ff, crc_in;
   logic [15:0] raw_ff;
   logic [7:0]  crc_lo_ff;
   logic        hdr_bad;
   logic [15:0] rx_crc;

   always_comb begin
      hdr_bad = ((pos_ff == POS_ADDR)  && (rx_byte != device_address)) ||
                ((pos_ff == POS_FUNC)  && (rx_byte != function_code))  ||
                ((pos_ff == POS_COUNT) && (rx_byte != COUNT_BYTE));
      rx_crc  = {rx_byte, crc_lo_ff};
   end

   always_comb begin
      pos_in     = pos_ff;
      crc_in     = crc_ff;
      evt.tick   = func;
      evt.status = FS_NONE;
      evt.cal    = (raw_ff > calib_offset) ? (raw_ff - calib_offset) : 16'd0;
      if (step && !func) begin
         if (hdr_bad) begin
            pos_in = POS_ADDR;
            crc_in = CRC_INIT;
         end else if (pos_ff != POS_CRC_H) begin
            pos_in = pos_ff + 3'd1;
            if (pos_ff < POS_CRC_L) crc_in = crc_step(crc_ff, rx_byte);
         end else begin
            pos_in = POS_ADDR;
            crc_in = CRC_INIT;
            priority if (rx_crc != crc_ff) evt.status = FS_CRC_ERR;
            else if (raw_ff > max_raw)     evt.status = FS_RANGE;
            else                           evt.status = FS_ACCEPT;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_ADDR;
         crc_ff <= CRC_INIT;
      end else begin
         pos_ff <= pos_in;
         crc_ff <= crc_in;
      end
   end

   // payload bytes, always written earlier in the same frame than they are read
   always_ff @(posedge clock) begin
      if (step && !func && !hdr_bad) begin
         if (pos_ff == POS_DIST_H) raw_ff[15:8] <= rx_byte;
         if (pos_ff == POS_DIST_L) raw_ff[7:0]  <= rx_byte;
         if (pos_ff == POS_CRC_L)  crc_lo_ff    <= rx_byte;
      end
   end

endmodule

// File: rtl/core/mrff_filter.sv
// Exponential average, rounded distance, valid flag and idle tick timeout.
`timescale 1ns / 1ps
module mrff_filter #(
   parameter int FRAC_BITS = mrff_pkg::FRAC_BITS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  mrff_pkg::event_type  evt,
   input  logic [2:0]           ema_shift,
   input  logic [15:0]          timeout_ticks,
   output mrff_pkg::result_type res
);
   import mrff_pkg::*;

   localparam int AW = 16 + FRAC_BITS;

   // average kept pre-biased by one half LSB of the integer part,
   // so the rounded output is just the upper 16 bits
   logic [AW-1:0]        avg_ff, avg_in;
   logic                 ready_ff, ready_in;
   logic                 valid_ff, valid_in;
   logic [15:0]          idle_ff, idle_in;
   logic [15:0]          dist_ff, dist_in;
   logic [2:0]           shamt;
   logic [AW-1:0]        target;
   logic signed [AW:0]   diff;
   logic signed [AW:0]   delta;
   logic                 accept;

   always_comb begin
      priority if (ema_shift < SHIFT_MIN) shamt = SHIFT_MIN;
      else if (ema_shift > SHIFT_MAX)     shamt = SHIFT_MAX;
      else                                shamt = ema_shift;
      target = {evt.cal, 1'b1, {(FRAC_BITS-1){1'b0}}};
      diff   = $signed({1'b0, target}) - $signed({1'b0, avg_ff});
      delta  = diff >>> shamt;
      accept = step && (evt.status == FS_ACCEPT);
   end

   always_comb begin
      avg_in   = avg_ff;
      ready_in = ready_ff;
      valid_in = valid_ff;
      idle_in  = idle_ff;
      if (step && evt.tick && (idle_ff != 16'hFFFF)) idle_in = idle_ff + 16'd1;
      if (accept) begin
         avg_in   = ready_ff ? (avg_ff + delta[AW-1:0]) : target;
         ready_in = 1'b1;
         valid_in = 1'b1;
         idle_in  = 16'd0;
      end
      if (idle_in > timeout_ticks) valid_in = 1'b0;
      dist_in = accept ? avg_in[AW-1:FRAC_BITS] : dist_ff;

      res.distance     = dist_in;
      res.valid_res    = valid_in;
      res.updated      = (evt.status == FS_ACCEPT);
      res.frame_status = evt.status;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ready_ff <= 1'b0;
         valid_ff <= 1'b0;
         idle_ff  <= 16'd0;
         dist_ff  <= 16'd0;
      end else if (step) begin
         ready_ff <= ready_in;
         valid_ff <= valid_in;
         idle_ff  <= idle_in;
         dist_ff  <= dist_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step) avg_ff <= avg_in;
   end

endmodule

// File: rtl/core/modbus_range_frame_filter.sv
// Top level of the Modbus range frame filter: beat pipeline and config registers.
//
//   channel  dir  handshake              payload
//   req_     in   req_tvalid/req_tready  tdata: rx_byte; tuser: func (0 byte, 1 tick)
//   rsp_     out  rsp_tvalid/rsp_tready  tdata: distance, valid_res, updated, frame_status
//   csr_     in   csr_we (no wait)       csr_addr register index, csr_wdata value
//
// One beat per cycle sustained while rsp_tready is high; each req beat yields exactly one rsp beat.
// The path is registered in order: input register, frame verdict register, result register.
// The parser stage settles CRC and range; the filter stage does the average update.
// Each stage holds while the one after it is full and stalled, so req_tready only
// drops when all three registers hold data and rsp_tready is low.
// reset is synchronous; it clears hunt, valid flag and tick count, restarts the average.
`timescale 1ns / 1ps
`include "modbus_range_frame_filter_defines.svh"
module modbus_range_frame_filter #(
   parameter int FRAC_BITS = mrff_pkg::FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // input stream
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [7:0]                      req_tdata,   // [7:0] rx_byte
   input  logic                            req_tuser,   // [0] func
   // result stream
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [23:0]                     rsp_tdata,   // [15:0] distance, [16] valid_res,
                                                        // [17] updated, [19:18] frame_status
   // register writes
   input  logic                            csr_we,
   input  logic [mrff_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [mrff_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import mrff_pkg::*;

   // config registers
   logic [7:0]  dev_addr_ff;
   logic [7:0]  func_code_ff;
   logic [15:0] calib_ff;
   logic [15:0] max_raw_ff;
   logic [2:0]  ema_shift_ff;
   logic [15:0] timeout_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         dev_addr_ff  <= RST_DEV_ADDR;
         func_code_ff <= RST_FUNC_CODE;
         calib_ff     <= RST_CALIB;
         max_raw_ff   <= RST_MAX_RAW;
         ema_shift_ff <= RST_EMA_SHIFT;
         timeout_ff   <= RST_TIMEOUT;
      end else if (csr_we) begin
         unique case (reg_index_type'(csr_addr))
            REG_DEV_ADDR:  dev_addr_ff  <= csr_wdata[7:0];
            REG_FUNC_CODE: func_code_ff <= csr_wdata[7:0];
            REG_CALIB:     calib_ff     <= csr_wdata;
            REG_MAX_RAW:   max_raw_ff   <= csr_wdata;
            REG_EMA_SHIFT: ema_shift_ff <= csr_wdata[2:0];
            REG_TIMEOUT:   timeout_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage valids and advance terms
   logic       s1_v_ff, s2_v_ff, s3_v_ff;
   logic       adv2, adv3;
   logic       in_func_ff;
   logic [7:0] in_byte_ff;
   event_type  evt, evt_ff;
   result_type res, res_ff;

   assign adv3       = s2_v_ff && (!s3_v_ff || rsp_tready);
   assign adv2       = s1_v_ff && (!s2_v_ff || adv3);
   assign req_tready = !s1_v_ff || adv2;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
         s2_v_ff <= 1'b0;
         s3_v_ff <= 1'b0;
      end else begin
         if (req_tready) s1_v_ff <= req_tvalid;
         if (adv2)       s2_v_ff <= 1'b1;
         else if (adv3)  s2_v_ff <= 1'b0;
         if (adv3)            s3_v_ff <= 1'b1;
         else if (rsp_tready) s3_v_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_func_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (adv2) evt_ff <= evt;
      if (adv3) res_ff <= res;
   end

   mrff_parser u_parser (
      .clock          (clock),
      .reset          (reset),
      .step           (adv2),
      .func           (in_func_ff),
      .rx_byte        (in_byte_ff),
      .device_address (dev_addr_ff),
      .function_code  (func_code_ff),
      .calib_offset   (calib_ff),
      .max_raw        (max_raw_ff),
      .evt            (evt)
   );

   mrff_filter #(
      .FRAC_BITS (FRAC_BITS)
   ) u_filter (
      .clock         (clock),
      .reset         (reset),
      .step          (adv3),
      .evt           (evt_ff),
      .ema_shift     (ema_shift_ff),
      .timeout_ticks (timeout_ff),
      .res           (res)
   );

   assign rsp_tvalid = s3_v_ff;
   assign rsp_tdata  = {4'b0000, res_ff};

   // a full, stalled pipe must not take another beat
   `MRFF_ASSERT_IMP(a_full_stall, clock, reset, s1_v_ff && s2_v_ff && s3_v_ff && !rsp_tready, !req_tready, "beat taken into full pipe")
   // an accepted frame always reports valid and updated
   `MRFF_ASSERT_IMP(a_accept_flags, clock, reset, rsp_tvalid && (res_ff.frame_status == FS_ACCEPT), res_ff.valid_res && res_ff.updated, "accepted frame without valid or updated")
   // a beat moved into the verdict stage is held there next cycle
   `MRFF_ASSERT_NXT(a_stage2_load, clock, reset, adv2, s2_v_ff, "verdict stage lost a beat")

endmodule
